// ===== hw/rtl/dmfs_pkg.sv =====
// Shared types, constants and the column mapping for the dot-matrix frame scan core.
// Used by every module under hw/rtl except dmfs_ram; depends on nothing.
package dmfs_pkg;

  localparam int PixelColumns = 120;
  localparam int PixelRows    = 8;
  localparam int BytesPerRow  = 16;
  localparam int PanelColumns = 30;
  localparam int PadBits      = 2;

  localparam int RowW      = (PixelRows > 1) ? $clog2(PixelRows) : 1;
  localparam int ByteW     = (BytesPerRow > 1) ? $clog2(BytesPerRow) : 1;
  localparam int AddrW     = RowW + ByteW;
  localparam int FrameDepth = 2 ** AddrW;
  localparam int NumPanels = (PixelColumns + PanelColumns - 1) / PanelColumns;
  localparam int PosW      = 9;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_SCAN  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_FILL,
    OP_SCAN
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIX_WR,
    ST_SCAN
  } exec_state_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [2:0]       bit_sel;
    logic             color;
  } cmd_t;

  // Column to bit position, two pad bits in front of every panel.
  function automatic logic [PosW-1:0] map_pos(input logic [6:0] x);
    logic [PosW-1:0] panel;
    panel = '0;
    for (int p = 1; p <= NumPanels; p++) begin
      if ({2'b00, x} >= PosW'(p * PanelColumns)) begin
        panel = PosW'(p);
      end
    end
    return PosW'(x) + (panel + PosW'(1)) * PosW'(PadBits);
  endfunction

endpackage

// ===== hw/rtl/dmfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dmfs_front.sv =====
// Front end: takes input words, holds the enable register, drops no-op words,
// out-of-range pixels and disabled scans, turns the rest into commands. Depends on dmfs_pkg.
module dmfs_front import dmfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [6:0] column_i,
  input  logic [2:0] line_i,
  input  logic       color_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic            enabled_q;
  logic            keep;
  logic [PosW-1:0] pos;
  logic            x_ok;
  logic            y_ok;
  logic            byte_ok;
  logic [RowW-1:0] row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
    end else if (cfg_we_i) begin
      enabled_q <= cfg_wdata_i;
    end
  end

  assign pos     = map_pos(column_i);
  assign x_ok    = 8'(column_i) < 8'(PixelColumns);
  assign y_ok    = 5'(line_i) < 5'(PixelRows);
  assign byte_ok = pos[PosW-1:3] < (PosW-3)'(BytesPerRow);
  assign row     = RowW'(PixelRows - 1) - RowW'(line_i);

  always_comb begin
    keep          = 1'b0;
    cmd_o.op      = OP_PIXEL;
    cmd_o.addr    = {row, pos[ByteW+2:3]};
    cmd_o.bit_sel = pos[2:0];
    cmd_o.color   = color_i;
    unique case (action_e'(action_i))
      ACT_PIXEL: begin
        keep     = x_ok && y_ok && byte_ok;
        cmd_o.op = OP_PIXEL;
      end
      ACT_FILL: begin
        keep     = 1'b1;
        cmd_o.op = OP_FILL;
      end
      ACT_SCAN: begin
        keep     = enabled_q;
        cmd_o.op = OP_SCAN;
      end
      ACT_NONE: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

// ===== hw/rtl/dmfs_queue.sv =====
// Two-entry command queue between front end and executor.
// Depends on dmfs_pkg.
module dmfs_queue import dmfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign do_pop  = pop_i && (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/dmfs_exec.sv =====
// Executor: owns the frame RAM, valid bits, fill value and scan row; does pixel
// read-modify-write, frame fill and row scan-out. Depends on dmfs_pkg, dmfs_ram.
module dmfs_exec import dmfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] shift_byte_o,
  output logic [2:0] row_address_o,
  output logic       latch_now_o
);

  exec_state_e state_q, state_d;

  cmd_t                  cmd_q;
  logic [RowW-1:0]       scan_row_q;
  logic                  fill_q;
  logic [FrameDepth-1:0] valid_q;
  logic [ByteW-1:0]      idx_q;
  logic                  iss_done_q;
  logic                  pend_q;
  logic                  pend_last_q;
  logic                  vbit_q;
  logic                  ov_q;
  logic [7:0]            obyte_q;
  logic [RowW-1:0]       orow_q;
  logic                  olatch_q;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic [7:0]       ram_rdata;
  logic [7:0]       rd_byte;
  logic [7:0]       bit_mask;
  logic             ov_free;
  logic             xfer;
  logic             issue;
  logic             scan_end;

  dmfs_ram #(
    .Width (8),
    .Depth (FrameDepth)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cmd_q.addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Entries not written since the last fill read as the fill value.
  assign rd_byte  = vbit_q ? ram_rdata : {8{fill_q}};
  assign bit_mask = 8'b1 << cmd_q.bit_sel;
  assign ov_free  = !ov_q || !out_stall_i;
  assign xfer     = pend_q && ov_free;
  assign scan_end = (state_q == ST_SCAN) && iss_done_q && !pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_PIXEL: state_d = ST_PIX_WR;
            OP_SCAN:  state_d = ST_SCAN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_PIX_WR: state_d = ST_IDLE;
      ST_SCAN: begin
        if (iss_done_q && !pend_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {scan_row_q, idx_q};
    wr_en     = 1'b0;
    wr_data   = cmd_q.color ? (rd_byte | bit_mask) : (rd_byte & ~bit_mask);
    issue     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i && cmd_i.op == OP_PIXEL) begin
          rd_en   = 1'b1;
          rd_addr = cmd_i.addr;
        end
      end
      ST_PIX_WR: begin
        wr_en = 1'b1;
      end
      ST_SCAN: begin
        issue = !iss_done_q && (!pend_q || xfer);
        rd_en = issue;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_row_q  <= '0;
      fill_q      <= 1'b0;
      valid_q     <= '0;
      idx_q       <= '0;
      iss_done_q  <= 1'b1;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      vbit_q      <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        vbit_q <= valid_q[rd_addr];
      end
      if (cmd_pop_o) begin
        if (cmd_i.op == OP_FILL) begin
          valid_q <= '0;
          fill_q  <= cmd_i.color;
        end
        if (cmd_i.op == OP_SCAN) begin
          idx_q      <= ByteW'(BytesPerRow - 1);
          iss_done_q <= 1'b0;
        end
      end
      if (wr_en) begin
        valid_q[cmd_q.addr] <= 1'b1;
      end
      if (issue) begin
        pend_last_q <= (idx_q == '0);
        if (idx_q == '0) begin
          iss_done_q <= 1'b1;
        end else begin
          idx_q <= idx_q - ByteW'(1);
        end
      end
      if (issue) begin
        pend_q <= 1'b1;
      end else if (xfer) begin
        pend_q <= 1'b0;
      end
      if (scan_end) begin
        scan_row_q <= (scan_row_q == RowW'(PixelRows - 1)) ? '0 : scan_row_q + RowW'(1);
      end
      if (xfer) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (xfer) begin
      obyte_q  <= rd_byte;
      orow_q   <= scan_row_q;
      olatch_q <= pend_last_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign shift_byte_o  = obyte_q;
  assign row_address_o = 3'(orow_q);
  assign latch_now_o   = olatch_q;

endmodule

// ===== hw/rtl/dot_matrix_frame_scan_core.sv =====
// Top level of the dot-matrix frame scan core: front end, command queue, executor.
// Depends on dmfs_pkg, dmfs_front, dmfs_queue, dmfs_exec (and dmfs_ram below it).
//
//  port group   | dir | handshake              | payload
//  -------------+-----+------------------------+------------------------------------
//  input word   | in  | in_valid_i / in_stall_o| action_i, column_i, line_i, color_i
//  result word  | out | out_valid_o/out_stall_i| shift_byte_o, row_address_o, latch_now_o
//  config       | in  | cfg_we_i               | cfg_wdata_i (display enable)
//
// Pixel draw reads the frame RAM, then writes the byte back; fill clears the valid
// bits at once; refresh pops the command, then reads 16 bytes, one byte per cycle
// while out_stall_i is low, through the single RAM read port, then read latency and a close.
// Reset: frame reads as zero via cleared valid bits, scan row 0, display enabled.
// The front end keeps accepting into a 2-entry queue while the executor works;
// out_stall_i holds the scan-out without losing a byte.
module dot_matrix_frame_scan_core import dmfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [6:0] column_i,
  input  logic [2:0] line_i,
  input  logic       color_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] shift_byte_o,
  output logic [2:0] row_address_o,
  output logic       latch_now_o
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  dmfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .column_i    (column_i),
    .line_i      (line_i),
    .color_i     (color_i),
    .full_i      (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  dmfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  dmfs_exec u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shift_byte_o  (shift_byte_o),
    .row_address_o (row_address_o),
    .latch_now_o   (latch_now_o)
  );

endmodule
